[sv/qte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, stage counts and the arctangent table for the quaternion to
// euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

  // component and angle widths
  localparam int CompW  = 16;
  localparam int AngW   = 16;

  // atan2 operand width (exact q30 sums, up to about 2^32 in magnitude)
  localparam int OpW    = 34;

  // clamped asin argument, -2^30..2^30 as a signed value
  localparam int ArgW   = 32;

  // normalization target is 2^NormExp, cordic datapath width
  localparam int NormExp = 40;
  localparam int NormW   = NormExp + 1;
  localparam int CordW   = 45;
  localparam int AccW    = 32;

  // cordic iterations and the shift steps of the normalizer
  localparam int CordicSteps = 28;
  localparam int NormSteps   = 6;
  localparam int NormShift [NormSteps] = '{32, 16, 8, 4, 2, 1};

  // integer square root: 61-bit radicand, 31-bit root, one bit per stage
  localparam int SqInW = 61;
  localparam int SqW   = 31;

  // pipeline depths
  localparam int AtanStages = 3 + CordicSteps + 1;
  localparam int FrontStages = 4;
  localparam int Latency = FrontStages + SqW + AtanStages;

  // atan(2^-i), 2^31 = pi
  localparam logic [AccW-1:0] AtanTab [CordicSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  localparam logic [AccW-1:0] HalfTurn = 32'h80000000;
  localparam logic [AccW-1:0] RoundBit = 32'h00008000;

  // operands carried alongside the square root
  typedef struct packed {
    logic signed [OpW-1:0]  t0;
    logic signed [OpW-1:0]  t1;
    logic signed [OpW-1:0]  t3;
    logic signed [OpW-1:0]  t4;
    logic signed [ArgW-1:0] s;
  } side_t;

endpackage

[sv/qte_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined exact floor square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module qte_isqrt import qte_pkg::*; (
  input  logic             clk,
  input  logic             ce,
  input  logic [SqInW-1:0] in_v,
  output logic [SqW-1:0]   out_q
);

  logic [SqInW-1:0] rem [0:SqW];
  logic [SqW-1:0]   root [0:SqW];

  assign rem[0]  = in_v;
  assign root[0] = '0;
  assign out_q   = root[SqW];

  // one stage per root bit, from the top bit down
  for (genvar k = 0; k < SqW; k++) begin : g_stage
    localparam int B = SqW - 1 - k;
    logic [SqInW:0] trial;
    logic [SqInW:0] rem_ext;
    logic           ge;

    assign trial   = ((SqInW + 1)'(root[k]) << (B + 1)) + ((SqInW + 1)'(1) << (2 * B));
    assign rem_ext = {1'b0, rem[k]};
    assign ge      = rem_ext >= trial;

    always_ff @(posedge clk) begin
      if (ce) begin
        if (ge) begin
          rem[k + 1]  <= SqInW'(rem_ext - trial);
          root[k + 1] <= root[k] | (SqW'(1) << B);
        end else begin
          rem[k + 1]  <= rem[k];
          root[k + 1] <= root[k];
        end
      end
    end
  end

endmodule

[sv/qte_atan2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_atan2
// Pipelined atan2: half-plane fold, two normalize stages, 28 cordic
// vectoring stages and a rounding stage to a 16-bit binary angle.
// ----------------------------------------------------------------------------
module qte_atan2 import qte_pkg::*; (
  input  logic                  clk,
  input  logic                  ce,
  input  logic signed [OpW-1:0] in_y,
  input  logic signed [OpW-1:0] in_x,
  output logic [AngW-1:0]       angle
);

  // fold stage
  logic signed [OpW-1:0] fx_next, fy_next, fx, fy;
  logic [OpW-2:0]        fm_next, fm;
  logic                  fhalf, fzero;
  logic [OpW-2:0]        ay;

  always_comb begin
    fx_next = in_x[OpW-1] ? -in_x : in_x;
    fy_next = in_x[OpW-1] ? -in_y : in_y;
    ay      = fy_next[OpW-1] ? (OpW-1)'(-fy_next) : (OpW-1)'(fy_next);
    fm_next = ((OpW-1)'(fx_next) > ay) ? (OpW-1)'(fx_next) : ay;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fx    <= fx_next;
      fy    <= fy_next;
      fm    <= fm_next;
      fhalf <= in_x[OpW-1];
      fzero <= (in_x == '0) && (in_y == '0);
    end
  end

  // first normalize stage: coarse shifts
  logic signed [CordW-1:0] nx_next, ny_next, nx, ny;
  logic [NormW-1:0]        nm_next, nm;
  logic                    nhalf, nzero;

  always_comb begin
    nx_next = CordW'(fx);
    ny_next = CordW'(fy);
    nm_next = NormW'(fm);
    for (int k = 0; k < 3; k++) begin
      if (nm_next < (NormW'(1) << (NormExp - NormShift[k]))) begin
        nx_next = nx_next <<< NormShift[k];
        ny_next = ny_next <<< NormShift[k];
        nm_next = nm_next << NormShift[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      nx    <= nx_next;
      ny    <= ny_next;
      nm    <= nm_next;
      nhalf <= fhalf;
      nzero <= fzero;
    end
  end

  // second normalize stage: fine shifts, then the last doubling
  logic signed [CordW-1:0] cx [0:CordicSteps];
  logic signed [CordW-1:0] cy [0:CordicSteps];
  logic [AccW-1:0]         ca [0:CordicSteps];
  logic                    cz [0:CordicSteps];
  logic signed [CordW-1:0] gx_next, gy_next;
  logic [NormW-1:0]        gm_next;

  always_comb begin
    gx_next = nx;
    gy_next = ny;
    gm_next = nm;
    for (int k = 3; k < NormSteps; k++) begin
      if (gm_next < (NormW'(1) << (NormExp - NormShift[k]))) begin
        gx_next = gx_next <<< NormShift[k];
        gy_next = gy_next <<< NormShift[k];
        gm_next = gm_next << NormShift[k];
      end
    end
    gx_next = gx_next <<< 1;
    gy_next = gy_next <<< 1;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cx[0] <= gx_next;
      cy[0] <= gy_next;
      ca[0] <= nhalf ? HalfTurn : '0;
      cz[0] <= nzero;
    end
  end

  // cordic vectoring, one micro-rotation per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (ce) begin
        if (!cy[i][CordW-1]) begin
          cx[i + 1] <= cx[i] + (cy[i] >>> i);
          cy[i + 1] <= cy[i] - (cx[i] >>> i);
          ca[i + 1] <= ca[i] + AtanTab[i];
        end else begin
          cx[i + 1] <= cx[i] - (cy[i] >>> i);
          cy[i + 1] <= cy[i] + (cx[i] >>> i);
          ca[i + 1] <= ca[i] - AtanTab[i];
        end
        cz[i + 1] <= cz[i];
      end
    end
  end

  // round to 16 bits, zero vector gives zero
  logic [AccW-1:0] rnd;
  assign rnd = ca[CordicSteps] + RoundBit;

  always_ff @(posedge clk) begin
    if (ce) begin
      angle <= cz[CordicSteps] ? '0 : rnd[AccW-1:AccW-AngW];
    end
  end

endmodule

[sv/quaternion_to_euler_angles.sv]
`timescale 1ns / 1ps
// pipeline: 4 front stages, 31 square root stages, 32 atan2 stages; throughput
// one beat per cycle while the output beat is accepted.
// the whole pipeline advances together and holds while the output beat waits.
// reset (rst, synchronous) clears only the valid bits; data registers are free.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Q1.15 quaternion to roll, pitch, yaw (zyx order) as 16-bit binary angles.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles import qte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // roll_angle, pitch_angle, yaw_angle
);

  logic ce;
  logic [Latency-1:0] vld;

  assign ce       = !vld[Latency-1] || m_tready;
  assign s_tready = ce && !rst;
  assign m_tvalid = vld[Latency-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[Latency-2:0], s_tvalid};
    end
  end

  logic signed [CompW-1:0] qx, qy, qz, qw;
  assign qx = s_tdata[15:0];
  assign qy = s_tdata[31:16];
  assign qz = s_tdata[47:32];
  assign qw = s_tdata[63:48];

  // stage 1: component products
  logic signed [2*CompW-1:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;

  always_ff @(posedge clk) begin
    if (ce) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
    end
  end

  // stage 2: atan2 and asin operands in q30
  localparam logic signed [OpW-1:0] One = OpW'(64'd1 << 30);
  logic signed [OpW-1:0] t0, t1, t2, t3, t4;

  always_ff @(posedge clk) begin
    if (ce) begin
      t0 <= (OpW'(p_wx) + OpW'(p_yz)) <<< 1;
      t1 <= One - ((OpW'(p_xx) + OpW'(p_yy)) <<< 1);
      t2 <= (OpW'(p_wy) - OpW'(p_zx)) <<< 1;
      t3 <= (OpW'(p_wz) + OpW'(p_xy)) <<< 1;
      t4 <= One - ((OpW'(p_yy) + OpW'(p_zz)) <<< 1);
    end
  end

  // stage 3: clamp the asin argument and square it
  logic signed [ArgW-1:0] s_clamp;
  logic [SqW-1:0]         s_mag;
  logic [2*SqW-1:0]       s_sq_next, s_sq;
  side_t                  side3, side4;

  always_comb begin
    if (t2 > One) begin
      s_clamp = ArgW'(One);
    end else if (t2 < -One) begin
      s_clamp = ArgW'(-One);
    end else begin
      s_clamp = ArgW'(t2);
    end
    s_mag     = s_clamp[ArgW-1] ? SqW'(-s_clamp) : SqW'(s_clamp);
    s_sq_next = s_mag * s_mag;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s_sq     <= s_sq_next;
      side3.t0 <= t0;
      side3.t1 <= t1;
      side3.t3 <= t3;
      side3.t4 <= t4;
      side3.s  <= s_clamp;
    end
  end

  // stage 4: radicand 1 - s^2
  logic [SqInW-1:0] rad;

  always_ff @(posedge clk) begin
    if (ce) begin
      rad   <= SqInW'(((2*SqW)'(1) << 60) - s_sq);
      side4 <= side3;
    end
  end

  // square root, with the other operands delayed to match
  logic [SqW-1:0] root;
  side_t          dl [0:SqW-1];

  qte_isqrt u_isqrt (
    .clk   (clk),
    .ce    (ce),
    .in_v  (rad),
    .out_q (root)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      dl[0] <= side4;
      for (int k = 1; k < SqW; k++) begin
        dl[k] <= dl[k - 1];
      end
    end
  end

  // three atan2 pipelines
  logic [AngW-1:0] roll_angle, pitch_angle, yaw_angle;
  logic signed [OpW-1:0] pitch_y, pitch_x;

  assign pitch_y = OpW'(dl[SqW-1].s);
  assign pitch_x = OpW'({1'b0, root});

  qte_atan2 u_roll (
    .clk   (clk),
    .ce    (ce),
    .in_y  (dl[SqW-1].t0),
    .in_x  (dl[SqW-1].t1),
    .angle (roll_angle)
  );

  qte_atan2 u_pitch (
    .clk   (clk),
    .ce    (ce),
    .in_y  (pitch_y),
    .in_x  (pitch_x),
    .angle (pitch_angle)
  );

  qte_atan2 u_yaw (
    .clk   (clk),
    .ce    (ce),
    .in_y  (dl[SqW-1].t3),
    .in_x  (dl[SqW-1].t4),
    .angle (yaw_angle)
  );

  assign m_tdata = {yaw_angle, pitch_angle, roll_angle};

endmodule
